/* rtl/ntlvp_pkg.sv */
// Shared types, constants and the tag classification table for the nested
// tagged-item stream parser. No dependencies.
package ntlvp_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int HDR_BYTES = 8;
    localparam int TAG_BYTES = 4;
    localparam int HCNT_W    = 4;

    typedef enum logic [1:0] {
        EV_OPEN    = 2'd0,
        EV_CLOSE   = 2'd1,
        EV_PAYLOAD = 2'd2,
        EV_END     = 2'd3
    } t_event_kind;

    typedef enum logic [2:0] {
        IT_UNKNOWN = 3'd0,
        IT_UINT    = 3'd1,
        IT_STRING  = 3'd2,
        IT_DATE    = 3'd3,
        IT_VERSION = 3'd4,
        IT_CONT    = 3'd5
    } t_item_type;

    typedef enum logic [2:0] {
        S_IN,
        S_PAY,
        S_CHG,
        S_EV,
        S_CLS
    } t_state;

    // One stack entry as it moves between neighboring cells.
    typedef struct packed {
        logic        occ;
        logic [31:0] tag;
        logic [31:0] rem;
    } t_entry;

    // Control broadcast from the sequencer to every stack cell.
    typedef struct packed {
        logic        push;
        logic        pop;
        logic        charge;
        logic        spare_top;
        logic [31:0] amount;
    } t_cell_ctrl;

    // Fixed tag table: maps four tag characters to an item type.
    function automatic t_item_type classify(input logic [31:0] tag);
        t_item_type r;
        case (tag)
            "abal", "abar", "abcp", "abgn", "abro", "adbs", "aeAD", "aemi", "aeml",
            "aply", "apso", "arif", "arsv", "avdb", "caci", "casp", "ceQR", "cmgt",
            "cmst", "ipsa", "ipsl", "mbcl", "mccr", "mcon", "mdcl", "mlcl", "mlit",
            "mlog", "msml", "msrv", "mudl", "mupd", "pefc", "pekm", "pfai", "pfdt",
            "pret": r = IT_CONT;
            "aeCD", "aeCR", "aeEN", "aeMX", "aeNN", "aeSN", "aeXD", "aecp", "agrp",
            "asaa", "asal", "asar", "ascm", "ascn", "ascp", "asct", "asdt", "aseq",
            "asfm", "asgn", "asky", "aslc", "aspu", "assa", "assc", "assl", "assn",
            "asss", "assu", "asul", "cana", "cang", "canl", "cann", "ceQa", "ceQg",
            "ceQn", "ceQr", "mcna", "minm", "msts", "pasp", "pcmt", "pfmt",
            "pimf": r = IT_STRING;
            "asda", "asdm", "asdp", "asdr", "askd", "aspl", "mstc", "peed", "pemd",
            "picd": r = IT_DATE;
            "aeSV", "apro", "capr", "cmpr", "mpro", "ppro": r = IT_VERSION;
            "abpl", "aeAI", "aeCF", "aeCI", "aeCK", "aeCM", "aeCS", "aeCU", "aeCd",
            "aeDP", "aeDR", "aeDV", "aeES", "aeGD", "aeGE", "aeGH", "aeGI", "aeGR",
            "aeGU", "aeGs", "aeHC", "aeHD", "aeHV", "aeK1", "aeK2", "aeMC", "aeMK",
            "aeMk", "aeND", "aeNV", "aePC", "aePI", "aePP", "aePS", "aeRD", "aeRP",
            "aeRS", "aeRU", "aeRf", "aeSE", "aeSF", "aeSG", "aeSI", "aeSP", "aeSU",
            "aels", "agac", "agma", "agmi", "aprm", "apsm", "asac", "asai", "asas",
            "asbk", "asbo", "asbr", "asbt", "ascd", "asco", "ascr", "ascs", "asdb",
            "asdc", "asdk", "asdn", "ased", "ases", "asgp", "asgr", "ashp", "askp",
            "aslr", "asls", "aspc", "asri", "asrs", "asrv", "assp", "assr", "asst",
            "assz", "astc", "astm", "astn", "asur", "asvc", "asyr", "ated", "caar",
            "caas", "cafe", "cafs", "caia", "canp", "cant", "caps", "carp", "cash",
            "cast", "cavc", "cave", "cavs", "ceJC", "ceJI", "ceJS", "ceJV", "cmmk",
            "cmsr", "cmvo", 32'h663F6368, "mcnm", "mctc", "mcti", "mcty", "mdbk",
            "mdst", "meds", "miid", "mikd", "mimc", "mlid", "mpco", "mper", "mrco",
            "mrpr", "msal", "msas", "msau", "msbr", "msdc", "msex", "msix", "mslr",
            "msma", "mspi", "msqy", "msrs", "mstm", "msto", "mstt", "msup", "mtco",
            "musr", "muty", "peak", "peki", "phgt", "pifs", "plsz", "prat",
            "pwth": r = IT_UINT;
            default: r = IT_UNKNOWN;
        endcase
        return r;
    endfunction

endpackage

/* rtl/ntlvp_if.sv */
// Valid/ready channel interfaces for the parser's byte input and event output.
// Depends on nothing.
interface ntlvp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ntlvp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [31:0] tag_code;
    logic [2:0]  item_type;
    logic [63:0] uint_value;
    logic [31:0] item_length;
    logic [7:0]  payload_byte;
    logic [4:0]  nest_depth;
    logic        last_result;

    modport source (output valid, output event_kind, output tag_code, output item_type,
                    output uint_value, output item_length, output payload_byte,
                    output nest_depth, output last_result, input ready);
    modport sink   (input valid, input event_kind, input tag_code, input item_type,
                    input uint_value, input item_length, input payload_byte,
                    input nest_depth, input last_result, output ready);
endinterface

/* rtl/ntlvp_stack_cell.sv */
// One cell of the container stack: holds one open container and trades it with
// its neighbors on push and pop. Depends on ntlvp_pkg.
module ntlvp_stack_cell
    import ntlvp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_is_top,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_prev,
    input  t_entry     i_next,
    input  logic       i_doom,
    output t_entry     o_entry,
    output logic       o_doom
);

    logic        r_occ;
    logic [31:0] r_tag;
    logic [31:0] r_rem;

    assign o_entry = '{occ: r_occ, tag: r_tag, rem: r_rem};

    // This cell closes if it or any outer cell has used up its length.
    assign o_doom = (r_occ && (r_rem == 32'd0)) || i_doom;

    // Occupancy shifts with the stack.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctrl.push) begin
            r_occ <= i_prev.occ;
        end else if (i_ctrl.pop) begin
            r_occ <= i_next.occ;
        end
    end

    // Entry payload shifts on push and pop and is charged in place.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_tag <= i_prev.tag;
            r_rem <= i_prev.rem;
        end else if (i_ctrl.pop) begin
            r_tag <= i_next.tag;
            r_rem <= i_next.rem;
        end else if (i_ctrl.charge && r_occ && !(i_ctrl.spare_top && i_is_top)) begin
            r_rem <= r_rem - i_ctrl.amount;
        end
    end

endmodule

/* rtl/nested_tlv_stream_parser_unit.sv */
// Top level of the nested tagged-item stream parser: header sequencer, output
// register and the chain of stack cells. Depends on ntlvp_pkg, ntlvp_if, ntlvp_stack_cell.
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    data_byte
//  o_out    out  valid/ready    event_kind .. last_result
//
// A header byte, or an unsigned payload byte that finishes nothing, is taken in S_IN.
// A string-like payload byte passes S_PAY. A container open, or an item finished by
// its header or by an unsigned byte, passes S_CHG and S_EV; an item finished by a
// string-like byte passes S_PAY first. S_CLS pops one cell per cycle unless output stalls.
// Output stalls hold the sequencer; input is taken only while it idles.
// Reset is synchronous and clears the control state and the stack occupancy.
module nested_tlv_stream_parser_unit
    import ntlvp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ntlvp_in_if.sink     i_in,
    ntlvp_out_if.source  o_out
);

    t_state              r_state, n_state;
    logic [HCNT_W-1:0]   r_hcnt, n_hcnt;
    logic [31:0]         r_tag, n_tag;
    logic [31:0]         r_len, n_len;
    logic [31:0]         r_rem, n_rem;
    t_item_type          r_type, n_type;
    logic [63:0]         r_acc, n_acc;
    logic [7:0]          r_byte, n_byte;
    logic [DEPTH_W-1:0]  r_count, n_count;
    logic                r_ev_open, n_ev_open;
    logic                r_fin, n_fin;

    logic                r_out_valid;
    t_event_kind         r_kind, n_kind;
    logic [31:0]         r_otag, n_otag;
    t_item_type          r_otype, n_otype;
    logic [63:0]         r_oval, n_oval;
    logic [31:0]         r_olen, n_olen;
    logic [7:0]          r_obyte, n_obyte;
    logic [DEPTH_W-1:0]  r_odepth, n_odepth;
    logic                r_olast, n_olast;
    logic                w_load;

    t_cell_ctrl          w_ctrl;
    t_entry              w_new;
    t_entry              w_ent  [0:MAX_DEPTH];
    logic                w_doom [0:MAX_DEPTH];
    logic                w_slot;
    logic [31:0]         w_len_new;
    t_item_type          w_cls;
    logic                w_full;

    assign w_ent[MAX_DEPTH]  = '0;
    assign w_doom[MAX_DEPTH] = 1'b0;

    // Chain of stack cells; cell 0 holds the innermost open container.
    for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_top
            ntlvp_stack_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_is_top(1'b1),
                .i_ctrl  (w_ctrl),
                .i_prev  (w_new),
                .i_next  (w_ent[k+1]),
                .i_doom  (w_doom[k+1]),
                .o_entry (w_ent[k]),
                .o_doom  (w_doom[k])
            );
        end else begin : g_inner
            ntlvp_stack_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_is_top(1'b0),
                .i_ctrl  (w_ctrl),
                .i_prev  (w_ent[k-1]),
                .i_next  (w_ent[k+1]),
                .i_doom  (w_doom[k+1]),
                .o_entry (w_ent[k]),
                .o_doom  (w_doom[k])
            );
        end
    end

    assign w_slot    = !r_out_valid || o_out.ready;
    assign w_len_new = {r_len[23:0], i_in.data_byte};
    assign w_cls     = classify(r_tag);
    assign w_full    = w_ent[MAX_DEPTH-1].occ;
    assign w_new     = '{occ: 1'b1, tag: r_tag, rem: w_len_new};
    assign i_in.ready = (r_state == S_IN);

    // Sequencer: next state, stack control and the event to load.
    always_comb begin
        n_state   = r_state;
        n_hcnt    = r_hcnt;
        n_tag     = r_tag;
        n_len     = r_len;
        n_rem     = r_rem;
        n_type    = r_type;
        n_acc     = r_acc;
        n_byte    = r_byte;
        n_count   = r_count;
        n_ev_open = r_ev_open;
        n_fin     = r_fin;
        w_ctrl    = '0;
        w_load    = 1'b0;
        n_kind    = EV_PAYLOAD;
        n_otag    = r_tag;
        n_otype   = r_type;
        n_oval    = 64'd0;
        n_olen    = r_len;
        n_obyte   = 8'd0;
        n_odepth  = r_count;
        n_olast   = 1'b1;
        case (r_state)
            S_IN: begin
                if (i_in.valid) begin
                    if (r_hcnt < HCNT_W'(HDR_BYTES)) begin
                        if (r_hcnt < HCNT_W'(TAG_BYTES)) begin
                            n_tag = {r_tag[23:0], i_in.data_byte};
                        end else begin
                            n_len = w_len_new;
                        end
                        n_hcnt = r_hcnt + 1'b1;
                        if (r_hcnt == HCNT_W'(HDR_BYTES - 1)) begin
                            n_acc = 64'd0;
                            if (w_cls == IT_CONT && !w_full) begin
                                w_ctrl.push = 1'b1;
                                n_count     = r_count + 1'b1;
                                n_ev_open   = 1'b1;
                                n_hcnt      = '0;
                                n_type      = IT_UNKNOWN;
                                n_state     = S_CHG;
                            end else begin
                                n_type = w_cls;
                                n_rem  = w_len_new;
                                if (w_len_new == 32'd0) begin
                                    n_ev_open = 1'b0;
                                    n_state   = S_CHG;
                                end
                            end
                        end
                    end else begin
                        n_rem     = r_rem - 32'd1;
                        n_fin     = (r_rem == 32'd1);
                        n_ev_open = 1'b0;
                        if (r_type == IT_UINT) begin
                            n_acc = {r_acc[55:0], i_in.data_byte};
                            if (r_rem == 32'd1) begin
                                n_state = S_CHG;
                            end
                        end else begin
                            n_byte  = i_in.data_byte;
                            n_state = S_PAY;
                        end
                    end
                end
            end
            S_PAY: begin
                if (w_slot) begin
                    w_load  = 1'b1;
                    n_kind  = EV_PAYLOAD;
                    n_obyte = r_byte;
                    n_olast = !r_fin;
                    n_state = r_fin ? S_CHG : S_IN;
                end
            end
            S_CHG: begin
                w_ctrl.charge    = 1'b1;
                w_ctrl.spare_top = r_ev_open;
                w_ctrl.amount    = r_ev_open ? 32'(HDR_BYTES) : r_len + 32'(HDR_BYTES);
                n_state          = S_EV;
            end
            S_EV: begin
                if (w_slot) begin
                    w_load  = 1'b1;
                    n_olast = !(w_ent[0].occ && w_doom[0]);
                    if (r_ev_open) begin
                        n_kind  = EV_OPEN;
                        n_otype = IT_CONT;
                    end else begin
                        n_kind = EV_END;
                        if (r_type == IT_UINT && (r_len == 32'd1 || r_len == 32'd2 ||
                                                  r_len == 32'd4 || r_len == 32'd8)) begin
                            n_oval = r_acc;
                        end
                        n_hcnt = '0;
                        n_type = IT_UNKNOWN;
                        n_acc  = 64'd0;
                    end
                    n_state = (w_ent[0].occ && w_doom[0]) ? S_CLS : S_IN;
                end
            end
            S_CLS: begin
                if (w_slot) begin
                    w_load     = 1'b1;
                    w_ctrl.pop = 1'b1;
                    n_count    = r_count - 1'b1;
                    n_kind     = EV_CLOSE;
                    n_otag     = w_ent[0].tag;
                    n_otype    = IT_CONT;
                    n_olen     = w_ent[0].rem;
                    n_odepth   = r_count - 1'b1;
                    n_olast    = !(w_ent[1].occ && w_doom[1]);
                    if (!(w_ent[1].occ && w_doom[1])) begin
                        n_state = S_IN;
                    end
                end
            end
            default: n_state = S_IN;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IN;
            r_hcnt      <= '0;
            r_tag       <= '0;
            r_len       <= '0;
            r_rem       <= '0;
            r_type      <= IT_UNKNOWN;
            r_acc       <= '0;
            r_count     <= '0;
            r_ev_open   <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hcnt    <= n_hcnt;
            r_tag     <= n_tag;
            r_len     <= n_len;
            r_rem     <= n_rem;
            r_type    <= n_type;
            r_acc     <= n_acc;
            r_count   <= n_count;
            r_ev_open <= n_ev_open;
            r_fin     <= n_fin;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload byte holding and the output event register.
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (w_load) begin
            r_kind   <= n_kind;
            r_otag   <= n_otag;
            r_otype  <= n_otype;
            r_oval   <= n_oval;
            r_olen   <= n_olen;
            r_obyte  <= n_obyte;
            r_odepth <= n_odepth;
            r_olast  <= n_olast;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_kind   = r_kind;
    assign o_out.tag_code     = r_otag;
    assign o_out.item_type    = r_otype;
    assign o_out.uint_value   = r_oval;
    assign o_out.item_length  = r_olen;
    assign o_out.payload_byte = r_obyte;
    assign o_out.nest_depth   = 5'(r_odepth);
    assign o_out.last_result  = r_olast;

    // The open count never exceeds the stack size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_W'(MAX_DEPTH))
        else $error("open count beyond stack depth");

    // The top cell is occupied exactly when a container is open.
    a_top_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ent[0].occ == (r_count != '0))
        else $error("stack occupancy disagrees with open count");

    // Closing only happens on an occupied stack.
    a_close_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLS) |-> w_ent[0].occ)
        else $error("close sequence on empty stack");

    // A charge is always followed by the pending open or end event.
    a_chg_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHG) |=> (r_state == S_EV))
        else $error("charge not followed by event");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the nested tagged-item stream parser.
// It depends on ntlvp_pkg, the ntlvp_in_if/ntlvp_out_if interfaces and the top level.
// Byte streams are predicted per accepted byte and every event is compared in order.
module testbench;
    import ntlvp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        t_event_kind ev;
        logic [31:0] tag;
        t_item_type  ty;
        logic [63:0] val;
        logic [31:0] len;
        logic [7:0]  pb;
        logic [4:0]  depth;
        logic        last;
    } event_t;

    typedef struct {
        logic [7:0] data;
        bit         drain_first;
    } stream_byte_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ntlvp_in_if  in_ch ();
    ntlvp_out_if out_ch ();

    nested_tlv_stream_parser_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    stream_byte_t stream_q[$];
    event_t       events_due[$];
    int           error_count = 0;
    int           send_idle = 0;
    int           recv_idle = 0;
    int           quiet_cycles = 0;
    bit           calm = 1'b0;
    bit           hold_output = 1'b0;
    bit           stream_loaded = 1'b0;

    // Parser state as the stream is predicted.
    logic [3:0]  hdr_cnt = '0;
    logic [31:0] cur_tag = '0;
    logic [31:0] cur_len = '0;
    logic [31:0] bytes_left = '0;
    t_item_type  cur_type = IT_UNKNOWN;
    logic [63:0] uint_acc = '0;
    logic [31:0] open_tags[MAX_DEPTH];
    logic [31:0] open_left[MAX_DEPTH];
    int          open_cnt = 0;

    // Tag pools for stream generation.
    logic [31:0] cont_tags[4] = '{"mlit", "mlcl", "mcon", "abal"};
    logic [31:0] uint_tags[4] = '{"mstt", "miid", "mikd", "asbr"};
    logic [31:0] str_tags[3]  = '{"minm", "asal", "asar"};
    logic [31:0] date_tags[2] = '{"asda", "mstc"};
    logic [31:0] ver_tags[2]  = '{"mpro", "apro"};

    function automatic void add_event(t_event_kind ev, logic [31:0] tag, t_item_type ty,
                                      logic [63:0] val, logic [31:0] len, logic [7:0] pb);
        event_t e;
        e.ev = ev; e.tag = tag; e.ty = ty; e.val = val; e.len = len; e.pb = pb;
        e.depth = open_cnt[4:0];
        e.last = 1'b0;
        events_due.push_back(e);
    endfunction

    // Charge the open containers and close from the innermost down to the outermost emptied one.
    function automatic void charge_open(bit spare_top, logic [31:0] amount);
        int lo;
        lo = open_cnt;
        for (int i = 0; i < open_cnt; i++)
            if (!(spare_top && i == open_cnt - 1)) open_left[i] -= amount;
        for (int i = open_cnt - 1; i >= 0; i--)
            if (open_left[i] == 0) lo = i;
        while (open_cnt > lo) begin
            open_cnt--;
            add_event(EV_CLOSE, open_tags[open_cnt], IT_CONT, '0, open_left[open_cnt], '0);
        end
    endfunction

    function automatic void end_item();
        logic [63:0] v;
        v = '0;
        if (cur_type == IT_UINT && (cur_len == 1 || cur_len == 2 || cur_len == 4 ||
                                    cur_len == 8))
            v = uint_acc;
        add_event(EV_END, cur_tag, cur_type, v, cur_len, '0);
        charge_open(1'b0, cur_len + HDR_BYTES);
        hdr_cnt = '0;
        cur_type = IT_UNKNOWN;
        uint_acc = '0;
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        int first_new;
        first_new = events_due.size();
        if (hdr_cnt < HDR_BYTES) begin
            if (hdr_cnt < TAG_BYTES) cur_tag = {cur_tag[23:0], b};
            else cur_len = {cur_len[23:0], b};
            hdr_cnt++;
            if (hdr_cnt == HDR_BYTES) begin
                cur_type = classify(cur_tag);
                uint_acc = '0;
                if (cur_type == IT_CONT && open_cnt < MAX_DEPTH) begin
                    open_tags[open_cnt] = cur_tag;
                    open_left[open_cnt] = cur_len;
                    open_cnt++;
                    add_event(EV_OPEN, cur_tag, IT_CONT, '0, cur_len, '0);
                    charge_open(1'b1, HDR_BYTES);
                    hdr_cnt = '0;
                    cur_type = IT_UNKNOWN;
                end else begin
                    bytes_left = cur_len;
                    if (bytes_left == 0) end_item();
                end
            end
        end else begin
            if (cur_type == IT_UINT) uint_acc = {uint_acc[55:0], b};
            else add_event(EV_PAYLOAD, cur_tag, cur_type, '0, cur_len, b);
            bytes_left--;
            if (bytes_left == 0) end_item();
        end
        if (events_due.size() > first_new) events_due[events_due.size() - 1].last = 1'b1;
    endfunction

    // Stream building helpers.
    function automatic byte_q_t header(logic [31:0] tag, logic [31:0] len);
        byte_q_t q;
        q = {tag[31:24], tag[23:16], tag[15:8], tag[7:0],
             len[31:24], len[23:16], len[15:8], len[7:0]};
        return q;
    endfunction

    function automatic byte_q_t leaf(logic [31:0] tag, int len);
        byte_q_t q;
        q = header(tag, len);
        repeat (len) q.push_back($urandom_range(0, 255));
        return q;
    endfunction

    function automatic byte_q_t random_item(int level);
        byte_q_t q, body;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3 && level < 3) begin
            repeat ($urandom_range(0, 3)) body = {body, random_item(level + 1)};
            q = {header(cont_tags[$urandom_range(0, 3)], body.size()), body};
        end else if (pick < 6) begin
            int lens[7] = '{1, 2, 4, 8, 8, 0, 3};
            q = leaf(uint_tags[$urandom_range(0, 3)], lens[$urandom_range(0, 6)]);
        end else if (pick == 6) q = leaf(str_tags[$urandom_range(0, 2)], $urandom_range(0, 6));
        else if (pick == 7) q = leaf(date_tags[$urandom_range(0, 1)], $urandom_range(0, 4));
        else if (pick == 8) q = leaf(ver_tags[$urandom_range(0, 1)], $urandom_range(0, 4));
        else q = leaf($urandom(), $urandom_range(0, 5));
        return q;
    endfunction

    // Containers nested n deep; the innermost one holds bottom_len random bytes.
    function automatic byte_q_t nest(int n, logic [31:0] bottom_len);
        byte_q_t inner;
        if (n == 1) return leaf(cont_tags[0], bottom_len);
        inner = nest(n - 1, bottom_len);
        return {header(cont_tags[n % 4], inner.size()), inner};
    endfunction

    function automatic void queue_bytes(byte_q_t q, bit drain_first);
        stream_byte_t s;
        foreach (q[i]) begin
            s.data = q[i];
            s.drain_first = drain_first && i == 0;
            stream_q.push_back(s);
        end
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("mismatch on %s: got %h, expected %h", field, got, want);
    endtask

    // Input driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_byte(in_ch.data_byte);
            if (in_ch.valid && !in_ch.ready) begin
                // Hold the request until it is taken.
            end else if (send_idle > 0) begin
                send_idle <= send_idle - 1;
                in_ch.valid <= 1'b0;
            end else if (stream_q.size() == 0 ||
                         (stream_q[0].drain_first && events_due.size() != 0)) begin
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.data_byte <= stream_q[0].data;
                in_ch.valid <= 1'b1;
                void'(stream_q.pop_front());
                if (!calm && $urandom_range(0, 9) == 0) send_idle <= $urandom_range(1, 5);
            end
        end
    end

    // Output monitor and checker.
    always @(posedge i_clk) begin
        event_t e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (events_due.size() == 0) begin
                    error_count++;
                    $display("unexpected event, kind %0d", out_ch.event_kind);
                end else begin
                    e = events_due.pop_front();
                    if (out_ch.event_kind !== e.ev) report("event_kind", out_ch.event_kind, e.ev);
                    if (out_ch.tag_code !== e.tag) report("tag_code", out_ch.tag_code, e.tag);
                    if (out_ch.item_type !== e.ty) report("item_type", out_ch.item_type, e.ty);
                    if (out_ch.uint_value !== e.val) report("uint_value", out_ch.uint_value, e.val);
                    if (out_ch.item_length !== e.len)
                        report("item_length", out_ch.item_length, e.len);
                    if (out_ch.payload_byte !== e.pb)
                        report("payload_byte", out_ch.payload_byte, e.pb);
                    if (out_ch.nest_depth !== e.depth)
                        report("nest_depth", out_ch.nest_depth, e.depth);
                    if (out_ch.last_result !== e.last)
                        report("last_result", out_ch.last_result, e.last);
                end
            end
            if (hold_output) begin
                out_ch.ready <= 1'b0;
            end else if (recv_idle > 0) begin
                recv_idle <= recv_idle - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) recv_idle <= $urandom_range(1, 5);
            end
        end
    end

    // Watchdog on cycles with no accepted request on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 2000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // One long receiver stall while the sender keeps offering bytes.
    initial begin
        wait (stream_loaded);
        repeat (300) @(posedge i_clk);
        hold_output = 1'b1;
        repeat (250) @(posedge i_clk);
        hold_output = 1'b0;
    end

    initial begin
        byte_q_t q;

        // Directed: uint widths, zero-length items and containers, types, deep nesting.
        queue_bytes(header(uint_tags[0], 1), 1'b0);
        queue_bytes({8'hff}, 1'b0);
        queue_bytes({header(uint_tags[1], 8), 8'hff, 8'hff, 8'hff, 8'hff,
                     8'hff, 8'hff, 8'hff, 8'hff}, 1'b0);
        queue_bytes({header(uint_tags[2], 2), 8'h00, 8'h80}, 1'b0);
        queue_bytes(leaf(uint_tags[3], 4), 1'b0);
        queue_bytes(leaf(uint_tags[0], 3), 1'b0);
        queue_bytes(leaf(uint_tags[0], 0), 1'b0);
        queue_bytes(leaf(str_tags[0], 0), 1'b0);
        queue_bytes(leaf(str_tags[1], 3), 1'b0);
        queue_bytes(leaf(date_tags[0], 4), 1'b0);
        queue_bytes(leaf(ver_tags[0], 4), 1'b0);
        queue_bytes(leaf(32'h00000000, 2), 1'b0);
        queue_bytes(leaf(32'hffffffff, 1), 1'b0);
        queue_bytes(header(cont_tags[1], 0), 1'b0);
        queue_bytes(nest(17, 3), 1'b0);
        // Outer container used up by the inner header: both close together.
        queue_bytes({header(cont_tags[2], 8), header(cont_tags[3], 5), leaf(uint_tags[0], 0)},
                    1'b0);

        // Random well-formed streams with some unknown tags mixed in.
        while (stream_q.size() < 330) begin
            q = random_item(0);
            queue_bytes(q, stream_q.size() > 290 && stream_q.size() < 310);
        end

        // Broken tail: oversize lengths and a charge that wraps a container.
        queue_bytes({header(cont_tags[0], 4), leaf(str_tags[2], 2)}, 1'b1);
        for (int i = 0; i < 4; i++)
            queue_bytes(header(cont_tags[i % 4], $urandom() | 32'h8000_0000), 1'b0);
        queue_bytes(leaf(cont_tags[1], 2), 1'b0);
        queue_bytes(leaf(uint_tags[1], 8), 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        stream_loaded = 1'b1;

        wait (stream_q.size() < 80);
        calm = 1'b1;
        wait (stream_q.size() == 0);
        @(posedge i_clk);
        while (in_ch.valid || events_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && events_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/ntlvp_pkg.sv
rtl/ntlvp_if.sv
rtl/ntlvp_stack_cell.sv
rtl/nested_tlv_stream_parser_unit.sv
tb/testbench.sv
